// ----- hdl/qft_pkg.sv -----
package qft_pkg;

   // vector and quaternion formats
   localparam int VEC_WIDTH      = 32;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;
   localparam int FRAME_WIDTH    = 3;

   // rotation datapath widths
   localparam int QP_WIDTH    = 2 * QUAT_WIDTH;
   localparam int MAT_WIDTH   = 2 * QUAT_WIDTH + 2;
   localparam int PROD_WIDTH  = MAT_WIDTH + VEC_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int ROUND_SHIFT = 2 * QUAT_FRAC_BITS;

   // register port geometry
   localparam int CSR_DATA_WIDTH = (VEC_WIDTH > 32 || QUAT_WIDTH > 32) ? 64 : 32;
   localparam int CSR_ADDR_LSB   = (CSR_DATA_WIDTH == 64) ? 3 : 2;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_ADDR_WIDTH = CSR_ADDR_LSB + CSR_IDX_WIDTH;

   // decoupling queue, depth a power of two
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
   localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};
   localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1 << QUAT_FRAC_BITS);
   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) << (ROUND_SHIFT - 1);

   // frame codes
   localparam logic [FRAME_WIDTH-1:0] FRAME_EYE    = 3'd0;
   localparam logic [FRAME_WIDTH-1:0] FRAME_HEAD   = 3'd1;
   localparam logic [FRAME_WIDTH-1:0] FRAME_BODY   = 3'd2;
   localparam logic [FRAME_WIDTH-1:0] FRAME_WORLD  = 3'd3;
   localparam logic [FRAME_WIDTH-1:0] FRAME_CAMERA = 3'd4;

   // register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_POS_X  = 3'd0,
      REG_POS_Y  = 3'd1,
      REG_POS_Z  = 3'd2,
      REG_QUAT_W = 3'd3,
      REG_QUAT_X = 3'd4,
      REG_QUAT_Y = 3'd5,
      REG_QUAT_Z = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] vec_x;
      logic signed [VEC_WIDTH-1:0] vec_y;
      logic signed [VEC_WIDTH-1:0] vec_z;
      logic [FRAME_WIDTH-1:0]      src_frame;
      logic [FRAME_WIDTH-1:0]      dst_frame;
   } req_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] out_x;
      logic signed [VEC_WIDTH-1:0] out_y;
      logic signed [VEC_WIDTH-1:0] out_z;
      logic                        saturated;
   } rsp_type;

   // classified item travelling through the back end
   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] vx;
      logic signed [VEC_WIDTH-1:0] vy;
      logic signed [VEC_WIDTH-1:0] vz;
      logic                        fwd;
      logic                        inv;
      logic                        clip;
   } job_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] px;
      logic signed [VEC_WIDTH-1:0] py;
      logic signed [VEC_WIDTH-1:0] pz;
   } pos_type;

   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0] w;
      logic signed [QUAT_WIDTH-1:0] x;
      logic signed [QUAT_WIDTH-1:0] y;
      logic signed [QUAT_WIDTH-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [MAT_WIDTH-1:0] m00;
      logic signed [MAT_WIDTH-1:0] m01;
      logic signed [MAT_WIDTH-1:0] m02;
      logic signed [MAT_WIDTH-1:0] m10;
      logic signed [MAT_WIDTH-1:0] m11;
      logic signed [MAT_WIDTH-1:0] m12;
      logic signed [MAT_WIDTH-1:0] m20;
      logic signed [MAT_WIDTH-1:0] m21;
      logic signed [MAT_WIDTH-1:0] m22;
   } mat_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] val;
      logic                        clip;
   } sat_type;

   // clamp a wide signed value to the vector range
   function automatic sat_type sat_vec(input logic signed [SUM_WIDTH-1:0] v);
      sat_type r;
      if (v > SUM_WIDTH'(VEC_MAX)) begin
         r.val  = VEC_MAX;
         r.clip = 1'b1;
      end else if (v < SUM_WIDTH'(VEC_MIN)) begin
         r.val  = VEC_MIN;
         r.clip = 1'b1;
      end else begin
         r.val  = v[VEC_WIDTH-1:0];
         r.clip = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- hdl/qft_front.sv -----
module qft_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qft_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output qft_pkg::job_type q_job
);
   import qft_pkg::*;

   logic    valid_ff;
   job_type job_ff;
   job_type job_in;
   logic    take;
   logic    diff;

   // hold one item while the queue is full
   assign req_ready = !valid_ff || q_ready;
   assign take      = req_valid && req_ready;
   assign q_valid   = valid_ff;
   assign q_job     = job_ff;

   // classify: rotate out of an eye, head or body frame, rotate into one, both, or pass
   always_comb begin
      diff        = req_data.src_frame != req_data.dst_frame;
      job_in.vx   = req_data.vec_x;
      job_in.vy   = req_data.vec_y;
      job_in.vz   = req_data.vec_z;
      job_in.fwd  = diff && (req_data.src_frame <= FRAME_BODY);
      job_in.inv  = diff && (req_data.dst_frame <= FRAME_BODY);
      job_in.clip = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (q_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

endmodule

// ----- hdl/qft_queue.sv -----
module qft_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qft_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output qft_pkg::job_type out_job
);
   import qft_pkg::*;

   job_type                    store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;
   logic                       push;
   logic                       pop;

   assign in_ready  = count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = store_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QUEUE_CNT_WIDTH'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QUEUE_CNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// ----- hdl/qft_rotate.sv -----
module qft_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic             in_active,
   input  qft_pkg::job_type in_job,
   input  qft_pkg::mat_type mat,
   output logic             out_valid,
   output qft_pkg::job_type out_job
);
   import qft_pkg::*;

   logic signed [MAT_WIDTH-1:0]  m [3][3];
   logic signed [VEC_WIDTH-1:0]  v [3];
   logic signed [PROD_WIDTH-1:0] prod_in [3][3];
   logic signed [PROD_WIDTH-1:0] prod_ff [3][3];
   logic signed [SUM_WIDTH-1:0]  acc [3];
   sat_type                      res [3];
   logic                         valid1_ff;
   logic                         active1_ff;
   job_type                      job1_ff;
   logic                         valid2_ff;
   job_type                      job2_ff;
   job_type                      job2_in;

   assign m[0][0] = mat.m00;
   assign m[0][1] = mat.m01;
   assign m[0][2] = mat.m02;
   assign m[1][0] = mat.m10;
   assign m[1][1] = mat.m11;
   assign m[1][2] = mat.m12;
   assign m[2][0] = mat.m20;
   assign m[2][1] = mat.m21;
   assign m[2][2] = mat.m22;
   assign v[0]    = in_job.vx;
   assign v[1]    = in_job.vy;
   assign v[2]    = in_job.vz;

   // stage 1: nine matrix by vector products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PROD_WIDTH'(m[i][j]) * PROD_WIDTH'(v[j]);
         end
      end
   end

   // stage 2: row sums, round half up, clamp
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = (SUM_WIDTH'(prod_ff[i][0]) + SUM_WIDTH'(prod_ff[i][1])
                  + SUM_WIDTH'(prod_ff[i][2]) + ROUND_HALF) >>> ROUND_SHIFT;
         res[i] = sat_vec(acc[i]);
      end
      job2_in = job1_ff;
      if (active1_ff) begin
         job2_in.vx   = res[0].val;
         job2_in.vy   = res[1].val;
         job2_in.vz   = res[2].val;
         job2_in.clip = job1_ff.clip || res[0].clip || res[1].clip || res[2].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         active1_ff <= in_active;
         job1_ff    <= in_job;
         job2_ff    <= job2_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_job   = job2_ff;

endmodule

// ----- hdl/qft_back.sv -----
module qft_back (
   input  logic              clock,
   input  logic              reset,
   input  qft_pkg::pos_type  pos,
   input  qft_pkg::quat_type quat,
   input  logic              q_valid,
   output logic              q_ready,
   input  qft_pkg::job_type  q_job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qft_pkg::rsp_type  rsp_data
);
   import qft_pkg::*;

   logic signed [QP_WIDTH-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff;
   logic signed [QP_WIDTH-1:0] wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   mat_type mat_ff;
   mat_type mat_in;
   mat_type mat_t;

   logic    advance;
   logic    s0_valid_ff;
   job_type s0_job_ff;
   logic    rot_a_valid;
   job_type rot_a_job;
   logic    s3_valid_ff;
   job_type s3_job_ff;
   job_type s3_job_in;
   logic    s4_valid_ff;
   job_type s4_job_ff;
   job_type s4_job_in;
   logic    rot_b_valid;
   job_type rot_b_job;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   sat_type add_res [3];
   sat_type sub_res [3];

   // quaternion products, refreshed every cycle
   always_ff @(posedge clock) begin
      ww_ff <= QP_WIDTH'(quat.w) * QP_WIDTH'(quat.w);
      xx_ff <= QP_WIDTH'(quat.x) * QP_WIDTH'(quat.x);
      yy_ff <= QP_WIDTH'(quat.y) * QP_WIDTH'(quat.y);
      zz_ff <= QP_WIDTH'(quat.z) * QP_WIDTH'(quat.z);
      xy_ff <= QP_WIDTH'(quat.x) * QP_WIDTH'(quat.y);
      wz_ff <= QP_WIDTH'(quat.w) * QP_WIDTH'(quat.z);
      xz_ff <= QP_WIDTH'(quat.x) * QP_WIDTH'(quat.z);
      wy_ff <= QP_WIDTH'(quat.w) * QP_WIDTH'(quat.y);
      yz_ff <= QP_WIDTH'(quat.y) * QP_WIDTH'(quat.z);
      wx_ff <= QP_WIDTH'(quat.w) * QP_WIDTH'(quat.x);
   end

   // rotation matrix entries
   always_comb begin
      mat_in.m00 = MAT_WIDTH'(ww_ff) + MAT_WIDTH'(xx_ff) - MAT_WIDTH'(yy_ff) - MAT_WIDTH'(zz_ff);
      mat_in.m11 = MAT_WIDTH'(ww_ff) - MAT_WIDTH'(xx_ff) + MAT_WIDTH'(yy_ff) - MAT_WIDTH'(zz_ff);
      mat_in.m22 = MAT_WIDTH'(ww_ff) - MAT_WIDTH'(xx_ff) - MAT_WIDTH'(yy_ff) + MAT_WIDTH'(zz_ff);
      mat_in.m01 = (MAT_WIDTH'(xy_ff) - MAT_WIDTH'(wz_ff)) <<< 1;
      mat_in.m10 = (MAT_WIDTH'(xy_ff) + MAT_WIDTH'(wz_ff)) <<< 1;
      mat_in.m02 = (MAT_WIDTH'(xz_ff) + MAT_WIDTH'(wy_ff)) <<< 1;
      mat_in.m20 = (MAT_WIDTH'(xz_ff) - MAT_WIDTH'(wy_ff)) <<< 1;
      mat_in.m12 = (MAT_WIDTH'(yz_ff) - MAT_WIDTH'(wx_ff)) <<< 1;
      mat_in.m21 = (MAT_WIDTH'(yz_ff) + MAT_WIDTH'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   // conjugate rotation is the transpose
   always_comb begin
      mat_t     = mat_ff;
      mat_t.m01 = mat_ff.m10;
      mat_t.m10 = mat_ff.m01;
      mat_t.m02 = mat_ff.m20;
      mat_t.m20 = mat_ff.m02;
      mat_t.m12 = mat_ff.m21;
      mat_t.m21 = mat_ff.m12;
   end

   // whole pipeline moves unless the result register is held
   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_ready = advance;

   // outbound rotation
   qft_rotate u_rot_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_active (s0_job_ff.fwd),
      .in_job    (s0_job_ff),
      .mat       (mat_ff),
      .out_valid (rot_a_valid),
      .out_job   (rot_a_job)
   );

   // add observer position after outbound rotation
   always_comb begin
      add_res[0] = sat_vec(SUM_WIDTH'(rot_a_job.vx) + SUM_WIDTH'(pos.px));
      add_res[1] = sat_vec(SUM_WIDTH'(rot_a_job.vy) + SUM_WIDTH'(pos.py));
      add_res[2] = sat_vec(SUM_WIDTH'(rot_a_job.vz) + SUM_WIDTH'(pos.pz));
      s3_job_in  = rot_a_job;
      if (rot_a_job.fwd) begin
         s3_job_in.vx   = add_res[0].val;
         s3_job_in.vy   = add_res[1].val;
         s3_job_in.vz   = add_res[2].val;
         s3_job_in.clip = rot_a_job.clip || add_res[0].clip || add_res[1].clip
                          || add_res[2].clip;
      end
   end

   // subtract observer position before inbound rotation
   always_comb begin
      sub_res[0] = sat_vec(SUM_WIDTH'(s3_job_ff.vx) - SUM_WIDTH'(pos.px));
      sub_res[1] = sat_vec(SUM_WIDTH'(s3_job_ff.vy) - SUM_WIDTH'(pos.py));
      sub_res[2] = sat_vec(SUM_WIDTH'(s3_job_ff.vz) - SUM_WIDTH'(pos.pz));
      s4_job_in  = s3_job_ff;
      if (s3_job_ff.inv) begin
         s4_job_in.vx   = sub_res[0].val;
         s4_job_in.vy   = sub_res[1].val;
         s4_job_in.vz   = sub_res[2].val;
         s4_job_in.clip = s3_job_ff.clip || sub_res[0].clip || sub_res[1].clip
                          || sub_res[2].clip;
      end
   end

   // inbound rotation by the conjugate
   qft_rotate u_rot_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_valid_ff),
      .in_active (s4_job_ff.inv),
      .in_job    (s4_job_ff),
      .mat       (mat_t),
      .out_valid (rot_b_valid),
      .out_job   (rot_b_job)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= q_valid;
         s3_valid_ff  <= rot_a_valid;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= rot_b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_job_ff             <= q_job;
         s3_job_ff             <= s3_job_in;
         s4_job_ff             <= s4_job_in;
         rsp_data_ff.out_x     <= rot_b_job.vx;
         rsp_data_ff.out_y     <= rot_b_job.vy;
         rsp_data_ff.out_z     <= rot_b_job.vz;
         rsp_data_ff.saturated <= rot_b_job.clip;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/quaternion_frame_transform.sv -----
// path from req transfer to rsp_valid: input register, queue, 8-stage back end
// one transfer per cycle unless stalled, set by the single pass through two rotation units
// a held result register freezes the back end; req_ready drops once queue and input reg fill
// reset: synchronous, active high; clears pipeline and queue, pose returns to identity at origin
// the rotation matrix follows a register write through the product and matrix registers
module quaternion_frame_transform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  qft_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output qft_pkg::rsp_type                     rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [qft_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [qft_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [qft_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import qft_pkg::*;

   logic signed [VEC_WIDTH-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [QUAT_WIDTH-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic [CSR_IDX_WIDTH-1:0]     csr_idx;
   logic                         csr_write;
   pos_type                      pos;
   quat_type                     quat;
   logic                         q_in_valid;
   logic                         q_in_ready;
   job_type                      q_in_job;
   logic                         q_out_valid;
   logic                         q_out_ready;
   job_type                      q_out_job;

   // register port
   assign pready    = 1'b1;
   assign csr_idx   = paddr[CSR_ADDR_WIDTH-1:CSR_ADDR_LSB];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
         quat_w_ff <= QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_POS_X:  pos_x_ff  <= pwdata[VEC_WIDTH-1:0];
            REG_POS_Y:  pos_y_ff  <= pwdata[VEC_WIDTH-1:0];
            REG_POS_Z:  pos_z_ff  <= pwdata[VEC_WIDTH-1:0];
            REG_QUAT_W: quat_w_ff <= pwdata[QUAT_WIDTH-1:0];
            REG_QUAT_X: quat_x_ff <= pwdata[QUAT_WIDTH-1:0];
            REG_QUAT_Y: quat_y_ff <= pwdata[QUAT_WIDTH-1:0];
            REG_QUAT_Z: quat_z_ff <= pwdata[QUAT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // read back, sign extended
   always_comb begin
      case (csr_idx)
         REG_POS_X:  prdata = CSR_DATA_WIDTH'(pos_x_ff);
         REG_POS_Y:  prdata = CSR_DATA_WIDTH'(pos_y_ff);
         REG_POS_Z:  prdata = CSR_DATA_WIDTH'(pos_z_ff);
         REG_QUAT_W: prdata = CSR_DATA_WIDTH'(quat_w_ff);
         REG_QUAT_X: prdata = CSR_DATA_WIDTH'(quat_x_ff);
         REG_QUAT_Y: prdata = CSR_DATA_WIDTH'(quat_y_ff);
         REG_QUAT_Z: prdata = CSR_DATA_WIDTH'(quat_z_ff);
         default:    prdata = '0;
      endcase
   end

   assign pos.px = pos_x_ff;
   assign pos.py = pos_y_ff;
   assign pos.pz = pos_z_ff;
   assign quat.w = quat_w_ff;
   assign quat.x = quat_x_ff;
   assign quat.y = quat_y_ff;
   assign quat.z = quat_z_ff;

   // accept and classify
   qft_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_in_valid),
      .q_ready   (q_in_ready),
      .q_job     (q_in_job)
   );

   // decoupling queue
   qft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_job    (q_in_job),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_job   (q_out_job)
   );

   // rotate, offset and clamp
   qft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pos       (pos),
      .quat      (quat),
      .q_valid   (q_out_valid),
      .q_ready   (q_out_ready),
      .q_job     (q_out_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   import qft_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int MAX_GAP         = 12;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 400;

   // frame codes with no frame of their own, handled like world
   localparam logic [FRAME_WIDTH-1:0] FRAME_SPARE_LO  = 3'd5;
   localparam logic [FRAME_WIDTH-1:0] FRAME_SPARE_MID = 3'd6;
   localparam logic [FRAME_WIDTH-1:0] FRAME_SPARE_HI  = 3'd7;

   // register slot past the pose registers, writes must be dropped
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // local copy of the observer pose
   logic signed [VEC_WIDTH-1:0]  pose_pos  [3];
   logic signed [QUAT_WIDTH-1:0] pose_quat [4];

   rsp_type predicted_positions [$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   bit      req_burst = 1'b0;
   bit      rsp_burst = 1'b0;

   quaternion_frame_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // clamp to the vector range, flag in the top bit
   function automatic logic [VEC_WIDTH:0] clamp_vec(input logic signed [127:0] v);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = 128'(VEC_MAX);
      lo_lim = 128'(VEC_MIN);
      if (v > hi_lim)
         return {1'b1, VEC_MAX};
      if (v < lo_lim)
         return {1'b1, VEC_MIN};
      return {1'b0, v[VEC_WIDTH-1:0]};
   endfunction

   // rotate by the pose quaternion (or its conjugate), exact sums, round half up
   function automatic rsp_type rotate_vec(input rsp_type v, input bit conj);
      longint              w, x, y, z;
      longint              m [3][3];
      logic signed [127:0] vin [3];
      logic signed [127:0] acc;
      logic signed [127:0] half;
      logic [VEC_WIDTH:0]  r [3];
      rsp_type             o;
      integer              i;
      w = 64'(pose_quat[0]);
      x = 64'(pose_quat[1]);
      y = 64'(pose_quat[2]);
      z = 64'(pose_quat[3]);
      if (conj) begin
         x = -x;
         y = -y;
         z = -z;
      end
      m[0][0] = w * w + x * x - y * y - z * z;
      m[0][1] = 2 * (x * y - w * z);
      m[0][2] = 2 * (x * z + w * y);
      m[1][0] = 2 * (x * y + w * z);
      m[1][1] = w * w - x * x + y * y - z * z;
      m[1][2] = 2 * (y * z - w * x);
      m[2][0] = 2 * (x * z - w * y);
      m[2][1] = 2 * (y * z + w * x);
      m[2][2] = w * w - x * x - y * y + z * z;
      vin[0] = 128'(v.out_x);
      vin[1] = 128'(v.out_y);
      vin[2] = 128'(v.out_z);
      half = 128'sd1 <<< (ROUND_SHIFT - 1);
      for (i = 0; i < 3; i++) begin
         acc = m[i][0] * vin[0] + m[i][1] * vin[1] + m[i][2] * vin[2] + half;
         acc = acc >>> ROUND_SHIFT;
         r[i] = clamp_vec(acc);
      end
      o.out_x = r[0][VEC_WIDTH-1:0];
      o.out_y = r[1][VEC_WIDTH-1:0];
      o.out_z = r[2][VEC_WIDTH-1:0];
      o.saturated = v.saturated | r[0][VEC_WIDTH] | r[1][VEC_WIDTH] | r[2][VEC_WIDTH];
      return o;
   endfunction

   // add or remove the observer position
   function automatic rsp_type shift_origin(input rsp_type v, input bit subtract);
      logic signed [127:0] s [3];
      logic [VEC_WIDTH:0]  r [3];
      rsp_type             o;
      integer              i;
      s[0] = 128'(v.out_x);
      s[1] = 128'(v.out_y);
      s[2] = 128'(v.out_z);
      for (i = 0; i < 3; i++) begin
         if (subtract)
            s[i] = s[i] - pose_pos[i];
         else
            s[i] = s[i] + pose_pos[i];
         r[i] = clamp_vec(s[i]);
      end
      o.out_x = r[0][VEC_WIDTH-1:0];
      o.out_y = r[1][VEC_WIDTH-1:0];
      o.out_z = r[2][VEC_WIDTH-1:0];
      o.saturated = v.saturated | r[0][VEC_WIDTH] | r[1][VEC_WIDTH] | r[2][VEC_WIDTH];
      return o;
   endfunction

   // expected position in the destination frame
   function automatic rsp_type transform_position(input req_type item);
      rsp_type v;
      v.out_x = item.vec_x;
      v.out_y = item.vec_y;
      v.out_z = item.vec_z;
      v.saturated = 1'b0;
      if (item.src_frame != item.dst_frame) begin
         // leave the observer frame: rotate, then move to world origin
         if (item.src_frame <= FRAME_BODY) begin
            v = rotate_vec(v, 1'b0);
            v = shift_origin(v, 1'b0);
         end
         // enter the observer frame: move origin, then rotate back
         if (item.dst_frame <= FRAME_BODY) begin
            v = shift_origin(v, 1'b1);
            v = rotate_vec(v, 1'b1);
         end
      end
      return v;
   endfunction

   function automatic logic [VEC_WIDTH-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return VEC_MAX;
               1: return VEC_MIN;
               2: return '0;
               3: return '1;
               default: return 1;
            endcase
         end
         1, 2: return $urandom;
         default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [FRAME_WIDTH-1:0] random_frame();
      if ($urandom_range(0, 7) < 6)
         return FRAME_WIDTH'($urandom_range(FRAME_EYE, FRAME_CAMERA));
      return FRAME_WIDTH'($urandom_range(FRAME_SPARE_LO, FRAME_SPARE_HI));
   endfunction

   task automatic report_mismatch(input string what, input logic [VEC_WIDTH-1:0] want,
                                  input logic [VEC_WIDTH-1:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
   endtask

   // one bus transfer; psel/penable stay up so the caller chains or idles in the same step
   task automatic csr_transfer(input bit is_write, input logic [CSR_IDX_WIDTH-1:0] idx,
                               input logic [CSR_DATA_WIDTH-1:0] wdata,
                               output logic [CSR_DATA_WIDTH-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_ADDR_WIDTH'(idx) << CSR_ADDR_LSB;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic write_pose_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] unused;
      csr_transfer(1'b1, idx, value, unused);
      case (idx)
         REG_POS_X:  pose_pos[0]  = value[VEC_WIDTH-1:0];
         REG_POS_Y:  pose_pos[1]  = value[VEC_WIDTH-1:0];
         REG_POS_Z:  pose_pos[2]  = value[VEC_WIDTH-1:0];
         REG_QUAT_W: pose_quat[0] = value[QUAT_WIDTH-1:0];
         REG_QUAT_X: pose_quat[1] = value[QUAT_WIDTH-1:0];
         REG_QUAT_Y: pose_quat[2] = value[QUAT_WIDTH-1:0];
         REG_QUAT_Z: pose_quat[3] = value[QUAT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // read every pose register back, then release the bus
   task automatic verify_pose_regs();
      logic [CSR_DATA_WIDTH-1:0] got;
      logic [CSR_DATA_WIDTH-1:0] want;
      logic [CSR_DATA_WIDTH-1:0] mask;
      integer                    idx;
      for (idx = REG_POS_X; idx <= REG_QUAT_Z; idx++) begin
         csr_transfer(1'b0, CSR_IDX_WIDTH'(idx), '0, got);
         // upper read bits of the quaternion registers are left open
         if (idx <= REG_POS_Z) begin
            want = pose_pos[idx];
            mask = '1;
         end else begin
            want = CSR_DATA_WIDTH'(pose_quat[idx - REG_QUAT_W]);
            mask = CSR_DATA_WIDTH'({QUAT_WIDTH{1'b1}});
         end
         if ((got & mask) !== (want & mask))
            report_mismatch("register readback", want & mask, got & mask);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // hold the sender until every predicted position has come back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (predicted_positions.size() != 0)
         @(posedge clock);
   endtask

   task automatic program_pose(input pos_type p, input quat_type q, input bit poke_unmapped);
      wait_for_idle();
      write_pose_reg(REG_POS_X, p.px);
      write_pose_reg(REG_POS_Y, p.py);
      write_pose_reg(REG_POS_Z, p.pz);
      // junk in the upper bits must not reach the quaternion
      write_pose_reg(REG_QUAT_W, {16'($urandom), q.w});
      write_pose_reg(REG_QUAT_X, {16'($urandom), q.x});
      write_pose_reg(REG_QUAT_Y, {16'($urandom), q.y});
      write_pose_reg(REG_QUAT_Z, {16'($urandom), q.z});
      if (poke_unmapped)
         write_pose_reg(REG_UNMAPPED, $urandom);
      verify_pose_regs();
   endtask

   // one input transfer after a random gap
   task automatic send_position(input logic [VEC_WIDTH-1:0] vx, input logic [VEC_WIDTH-1:0] vy,
                                input logic [VEC_WIDTH-1:0] vz,
                                input logic [FRAME_WIDTH-1:0] sf,
                                input logic [FRAME_WIDTH-1:0] df);
      req_type item;
      int      gap;
      item.vec_x     = vx;
      item.vec_y     = vy;
      item.vec_z     = vz;
      item.src_frame = sf;
      item.dst_frame = df;
      if ($urandom_range(0, 31) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted_positions.push_back(transform_position(item));
   endtask

   // identity pose at the origin straight out of reset
   task automatic test_reset_pose();
      verify_pose_regs();
      send_position(VEC_MAX, VEC_MIN, 32'hFFFF_FFFF, FRAME_EYE, FRAME_WORLD);
      send_position(VEC_MIN, VEC_MAX, 32'h0000_0000, FRAME_WORLD, FRAME_EYE);
      send_position(32'h0000_0001, 32'hFFFF_FFFF, VEC_MAX, FRAME_HEAD, FRAME_BODY);
      send_position(32'h0001_0000, 32'h8000_0001, 32'h7FFF_FFFE, FRAME_EYE, FRAME_EYE);
   endtask

   // quarter turn about z with an offset, every class of frame pair
   task automatic test_rotated_pose();
      pos_type  p;
      quat_type q;
      p = {32'h0001_8000, 32'hFFFE_0000, 32'h0003_4000};
      q = {16'd11585, 16'd0, 16'd0, 16'd11585};
      program_pose(p, q, 1'b0);
      send_position(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, FRAME_EYE, FRAME_WORLD);
      send_position(32'h0001_2345, 32'hFFF9_8766, 32'h0000_0100, FRAME_HEAD, FRAME_CAMERA);
      send_position(32'h0001_8000, 32'hFFFE_0000, 32'h0003_4000, FRAME_WORLD, FRAME_BODY);
      send_position(32'h0010_0000, 32'h0020_0000, 32'hFFC0_0000, FRAME_CAMERA, FRAME_HEAD);
      send_position(VEC_MAX, 32'h0000_0000, VEC_MIN, FRAME_EYE, FRAME_HEAD);
      send_position(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, FRAME_BODY, FRAME_EYE);
      send_position(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, FRAME_SPARE_LO, FRAME_EYE);
      send_position(32'h7654_3210, 32'hF00D_F00D, 32'h0000_0000, FRAME_EYE, FRAME_SPARE_MID);
      send_position(VEC_MIN, VEC_MAX, 32'h0000_0000, FRAME_SPARE_HI, FRAME_WORLD);
      send_position(VEC_MAX, VEC_MIN, VEC_MAX, FRAME_SPARE_MID, FRAME_SPARE_MID);
      send_position(VEC_MIN, VEC_MIN, VEC_MIN, FRAME_WORLD, FRAME_CAMERA);
      send_position(VEC_MAX, VEC_MAX, VEC_MIN, FRAME_BODY, FRAME_BODY);
   endtask

   // largest quaternion and offsets, unnormalized, clipping at every stage
   task automatic test_extreme_pose();
      pos_type  p;
      quat_type q;
      p = {VEC_MAX, VEC_MIN, 32'h8000_0001};
      q = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      program_pose(p, q, 1'b1);
      send_position(VEC_MAX, VEC_MIN, VEC_MAX, FRAME_EYE, FRAME_WORLD);
      send_position(VEC_MIN, VEC_MIN, VEC_MAX, FRAME_WORLD, FRAME_HEAD);
      send_position(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, FRAME_HEAD, FRAME_EYE);
      send_position(VEC_MIN, VEC_MAX, 32'h0000_0000, FRAME_EYE, FRAME_EYE);
      send_position(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, FRAME_BODY, FRAME_CAMERA);
   endtask

   // random poses, each followed by a stream of random positions
   task automatic test_random_poses();
      pos_type                      p;
      quat_type                     q;
      logic signed [QUAT_WIDTH-1:0] c [4];
      logic [FRAME_WIDTH-1:0]       sf;
      logic [FRAME_WIDTH-1:0]       df;
      integer                       phase;
      integer                       n;
      integer                       k;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         p.px = random_coord();
         p.py = random_coord();
         p.pz = random_coord();
         for (k = 0; k < 4; k++)
            c[k] = '0;
         // one unit component, two at +-1/sqrt2, all four at +-1/2, or anything at all
         case ($urandom_range(0, 3))
            0: c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            1: begin
               k = $urandom_range(0, 3);
               c[k] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
               c[(k + 1 + $urandom_range(0, 2)) % 4] =
                  $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
            end
            2: begin
               for (k = 0; k < 4; k++)
                  c[k] = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
            end
            default: begin
               for (k = 0; k < 4; k++)
                  c[k] = 16'($urandom);
            end
         endcase
         q = {c[0], c[1], c[2], c[3]};
         program_pose(p, q, phase == 0);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            sf = random_frame();
            df = ($urandom_range(0, 7) == 0) ? sf : random_frame();
            send_position(random_coord(), random_coord(), random_coord(), sf, df);
         end
      end
   endtask

   // result side: random stalls, compare each transfer with the oldest prediction
   initial begin : result_checker
      rsp_type expected_rsp;
      rsp_type actual_rsp;
      int      stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         actual_rsp = rsp_data;
         if (predicted_positions.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, actual_rsp);
            mismatch_count++;
         end else begin
            expected_rsp = predicted_positions.pop_front();
            if (actual_rsp.out_x !== expected_rsp.out_x)
               report_mismatch("out_x", expected_rsp.out_x, actual_rsp.out_x);
            if (actual_rsp.out_y !== expected_rsp.out_y)
               report_mismatch("out_y", expected_rsp.out_y, actual_rsp.out_y);
            if (actual_rsp.out_z !== expected_rsp.out_z)
               report_mismatch("out_z", expected_rsp.out_z, actual_rsp.out_z);
            if (actual_rsp.saturated !== expected_rsp.saturated)
               report_mismatch("saturated", VEC_WIDTH'(expected_rsp.saturated),
                               VEC_WIDTH'(actual_rsp.saturated));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      pose_pos[0]  = '0;
      pose_pos[1]  = '0;
      pose_pos[2]  = '0;
      pose_quat[0] = QUAT_ONE;
      pose_quat[1] = '0;
      pose_quat[2] = '0;
      pose_quat[3] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_pose();
      test_rotated_pose();
      test_extreme_pose();
      test_random_poses();
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
